// ===== rtl/i32alu_pkg.sv =====
// Package for the signed 32-bit elementwise ALU: operation codes and the
// record that travels down the arithmetic pipeline. No dependencies.
package i32alu_pkg;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_MAX  = 3'd4;
   localparam logic [2:0] OP_MIN  = 3'd5;
   localparam logic [2:0] OP_CSGN = 3'd6;
   localparam logic [2:0] OP_POW  = 3'd7;

   // One radix-2 divide step per stage; a square-and-multiply step in the stages below POW_STEPS.
   localparam int unsigned NUM_STEPS = 32;
   localparam int unsigned POW_STEPS = 31;

   typedef struct packed {
      logic        valid;
      logic [2:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] res;   // result of the operations that finish in the preparation stage
      logic [32:0] rem;   // partial remainder of |a| / |b|
      logic [31:0] quo;   // dividend bits shifting out, quotient bits in
      logic [31:0] dvs;   // divisor magnitude
      logic [31:0] acc;   // power accumulator
      logic [31:0] sq;    // repeated square of the base
   } stage_type;

endpackage

// ===== rtl/i32alu_ifs.sv =====
// Handshake interfaces for the ALU: operand, result and register-write
// channels. Depends on nothing.
interface i32alu_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] a_value;
   logic signed [31:0] b_value;
   modport source (output valid, a_value, b_value, input ready);
   modport sink   (input valid, a_value, b_value, output ready);
endinterface

interface i32alu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic               divide_by_zero;
   modport source (output valid, result_value, divide_by_zero, input ready);
   modport sink   (input valid, result_value, divide_by_zero, output ready);
endinterface

interface i32alu_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   modport source (output valid, operation, input ready);
   modport sink   (input valid, operation, output ready);
endinterface

// ===== rtl/int32_elementwise_binary_alu.sv =====
// Signed 32-bit elementwise ALU, fully pipelined.
// Throughput: one operand beat per cycle; the pipeline stalls as a whole only
// when the result register holds a beat that the sink does not take.
// A beat passes 35 registers (input register, operand preparation,
// 32 divide/power stages, result register).
// Reset (synchronous, active high) empties the
// pipeline and sets the operation register to add.
module int32_elementwise_binary_alu import i32alu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   i32alu_req_if.sink   req_bus,
   i32alu_rsp_if.source rsp_bus,
   i32alu_csr_if.sink   csr_bus
);

   // The whole pipeline moves together. It advances whenever the result
   // register is empty or its beat is being taken this cycle, so a new
   // operand beat can enter every cycle while results flow out.
   logic advance;

   logic [2:0] operation_ff;
   logic [2:0] operation_in;

   // Input register.
   logic        in_valid_ff;
   logic [2:0]  in_op_ff;
   logic [31:0] in_a_ff;
   logic [31:0] in_b_ff;

   // Preparation results and the chain of step stages.
   stage_type prep_in;
   stage_type prep_ff;
   stage_type chain [NUM_STEPS+1];

   // Result register.
   logic        out_valid_ff;
   logic [31:0] out_res_ff;
   logic        out_dz_ff;
   logic [31:0] out_res_in;
   logic        out_dz_in;

   assign advance         = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready   = advance;
   assign csr_bus.ready   = 1'b1;

   // The operation register. Write it only while the block is idle; the block does not enforce this.
   assign operation_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.operation
                                                         : operation_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff <= OP_ADD;
      end else begin
         operation_ff <= operation_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_bus.valid;
      end
      if (advance) begin
         in_op_ff <= operation_ff;
         in_a_ff  <= req_bus.a_value;
         in_b_ff  <= req_bus.b_value;
      end
   end

   // Preparation stage: all operations but divide and power finish here, and the
   // divider and power chain get their starting values. The divider works
   // on magnitudes; signs are applied again at the end.
   logic        a_neg;
   logic        b_neg;
   logic [31:0] a_mag;
   logic [31:0] b_mag;
   logic        a_gt_b;

   always_comb begin
      a_neg  = in_a_ff[31];
      b_neg  = in_b_ff[31];
      a_mag  = a_neg ? (32'd0 - in_a_ff) : in_a_ff;
      b_mag  = b_neg ? (32'd0 - in_b_ff) : in_b_ff;
      a_gt_b = $signed(in_a_ff) > $signed(in_b_ff);

      prep_in.valid = in_valid_ff;
      prep_in.op    = in_op_ff;
      prep_in.a     = in_a_ff;
      prep_in.b     = in_b_ff;
      prep_in.rem   = 33'd0;
      prep_in.quo   = a_mag;
      prep_in.dvs   = b_mag;
      prep_in.acc   = 32'd1;
      prep_in.sq    = in_a_ff;
      case (in_op_ff)
         OP_ADD:  prep_in.res = in_a_ff + in_b_ff;
         OP_SUB:  prep_in.res = in_a_ff - in_b_ff;
         OP_MUL:  prep_in.res = in_a_ff * in_b_ff;
         OP_MAX:  prep_in.res = a_gt_b ? in_a_ff : in_b_ff;
         OP_MIN:  prep_in.res = (!a_gt_b && in_a_ff != in_b_ff) ? in_a_ff : in_b_ff;
         OP_CSGN: prep_in.res = b_neg ? (32'd0 - a_mag) : a_mag;
         default: prep_in.res = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (advance) begin
         prep_ff.valid <= prep_in.valid;
      end
      if (advance) begin
         prep_ff.op  <= prep_in.op;
         prep_ff.a   <= prep_in.a;
         prep_ff.b   <= prep_in.b;
         prep_ff.res <= prep_in.res;
         prep_ff.rem <= prep_in.rem;
         prep_ff.quo <= prep_in.quo;
         prep_ff.dvs <= prep_in.dvs;
         prep_ff.acc <= prep_in.acc;
         prep_ff.sq  <= prep_in.sq;
      end
   end

   // Each step stage retires one quotient bit (most significant first); each
   // stage below POW_STEPS also retires one exponent bit (least significant first).
   assign chain[0] = prep_ff;

   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      i32alu_step #(.STEP(k)) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (chain[k]),
         .stage_out (chain[k+1])
      );
   end

   // Finishing: Euclidean correction of the truncated quotient and the
   // special cases of a negative exponent.
   stage_type   fin;
   logic [31:0] q_trunc;
   logic [31:0] euclid;
   logic        rem_nz;
   logic [31:0] pow_res;

   always_comb begin
      fin     = chain[NUM_STEPS];
      rem_nz  = fin.rem != 33'd0;
      q_trunc = (fin.a[31] ^ fin.b[31]) ? (32'd0 - fin.quo) : fin.quo;
      // A negative dividend with a nonzero remainder leaves a negative
      // truncated remainder; move the quotient one step away from zero.
      if (fin.a[31] && rem_nz) begin
         euclid = fin.b[31] ? (q_trunc + 32'd1) : (q_trunc - 32'd1);
      end else begin
         euclid = q_trunc;
      end
      if (!fin.b[31]) begin
         pow_res = fin.acc;
      end else if (fin.a == 32'd1) begin
         pow_res = 32'd1;
      end else if (fin.a == 32'hFFFF_FFFF) begin
         pow_res = fin.b[0] ? 32'hFFFF_FFFF : 32'd1;
      end else begin
         pow_res = 32'd0;
      end
      out_dz_in = 1'b0;
      case (fin.op)
         OP_DIV: begin
            if (fin.b == 32'd0) begin
               out_res_in = 32'd0;
               out_dz_in  = 1'b1;
            end else begin
               out_res_in = euclid;
            end
         end
         OP_POW:  out_res_in = pow_res;
         default: out_res_in = fin.res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= fin.valid;
      end
      if (advance) begin
         out_res_ff <= out_res_in;
         out_dz_ff  <= out_dz_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.result_value   = out_res_ff;
   assign rsp_bus.divide_by_zero = out_dz_ff;

endmodule

// ===== rtl/i32alu_step.sv =====
// One pipeline stage of the ALU: a restoring divide step and, for the early
// stages, a square-and-multiply power step. Depends on i32alu_pkg.
module i32alu_step import i32alu_pkg::*; #(
   parameter int unsigned STEP = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  stage_type stage_in,
   output stage_type stage_out
);

   stage_type   stage_ff;
   stage_type   stage_in_w;
   logic [32:0] shifted;
   logic [33:0] diff;
   logic        fits;

   always_comb begin
      stage_in_w = stage_in;
      shifted    = {stage_in.rem[31:0], stage_in.quo[31]};
      diff       = {1'b0, shifted} - {2'b00, stage_in.dvs};
      fits       = !diff[33];
      stage_in_w.rem = fits ? diff[32:0] : shifted;
      stage_in_w.quo = {stage_in.quo[30:0], fits};
      if (STEP < POW_STEPS) begin
         if (stage_in.b[STEP]) begin
            stage_in_w.acc = stage_in.acc * stage_in.sq;
         end
         stage_in_w.sq = stage_in.sq * stage_in.sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in_w.valid;
      end
      if (advance) begin
         stage_ff.op  <= stage_in_w.op;
         stage_ff.a   <= stage_in_w.a;
         stage_ff.b   <= stage_in_w.b;
         stage_ff.res <= stage_in_w.res;
         stage_ff.rem <= stage_in_w.rem;
         stage_ff.quo <= stage_in_w.quo;
         stage_ff.dvs <= stage_in_w.dvs;
         stage_ff.acc <= stage_in_w.acc;
         stage_ff.sq  <= stage_in_w.sq;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/i32alu_checker.sv =====
// Port-level checks for the ALU, attached to the top level by a bind.
// Depends on the top level and its interfaces.
module i32alu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result,
   input logic        rsp_dz
);

   // A beat that waits keeps its valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A beat that waits keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result) && $stable(rsp_dz))
      else $error("result payload changed while stalled");

   // A blocked result stalls the whole pipeline, input side included.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("operand accepted while pipeline is stalled");

   // A division by zero always reports a zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dz |-> rsp_result == 32'd0)
      else $error("divide by zero with nonzero result");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind int32_elementwise_binary_alu i32alu_checker u_i32alu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_result (rsp_bus.result_value),
   .rsp_dz     (rsp_bus.divide_by_zero)
);

// ===== sim/tb_int32_elementwise_binary_alu.sv =====
// Testbench for the signed 32-bit elementwise ALU: directed and random operand
// beats under every operation, with a software predictor and a result scoreboard.
// Depends on i32alu_pkg, the handshake interfaces and the ALU top level.
`timescale 1ns / 1ps
module tb_int32_elementwise_binary_alu;
   import i32alu_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i32alu_req_if req_bus ();
   i32alu_rsp_if rsp_bus ();
   i32alu_csr_if csr_bus ();

   int32_elementwise_binary_alu uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #6 clock = ~clock;

   // One expected result beat.
   typedef struct {
      logic [31:0] value;
      logic        dz;
   } alu_result_type;

   alu_result_type expected_results[$];
   logic [2:0]  active_op;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_off_cycles;
   int          error_count;
   int          beats_sent;
   int          beats_checked;
   bit [7:0]    ops_seen;

   // Euclidean quotient: truncating divide, then pull the remainder nonnegative.
   function automatic logic [31:0] euclid_quotient(longint a, longint b);
      longint q;
      longint r;
      q = a / b;
      r = a - q * b;
      if (r < 0) begin
         if (b > 0) begin
            q = q - 1;
         end else begin
            q = q + 1;
         end
      end
      return q[31:0];
   endfunction

   // Integer power by square and multiply, wrapping to 32 bits; a negative exponent gives 1, -1 or 0.
   function automatic logic [31:0] int_power(logic signed [31:0] base, logic signed [31:0] ex);
      logic [31:0] acc;
      logic [31:0] sq;
      acc = 32'd1;
      if (ex < 0) begin
         if (base == 1) return 32'd1;
         if (base == -1) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
         return 32'd0;
      end
      sq = base;
      for (int k = 0; k < 31; k++) begin
         if (ex[k]) acc = acc * sq;
         sq = sq * sq;
      end
      return acc;
   endfunction

   // Predicts the result beat for one operand pair under the active operation.
   function automatic alu_result_type alu_predict(logic signed [31:0] a, logic signed [31:0] b);
      alu_result_type r;
      logic [31:0] mag;
      r.dz = 1'b0;
      r.value = '0;
      case (active_op)
         OP_ADD:  r.value = a + b;
         OP_SUB:  r.value = a - b;
         OP_MUL:  r.value = a * b;
         OP_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               r.value = euclid_quotient(longint'(a), longint'(b));
            end
         end
         OP_MAX:  r.value = (a > b) ? a : b;
         OP_MIN:  r.value = (a < b) ? a : b;
         OP_CSGN: begin
            mag = (a < 0) ? -a : a;
            r.value = (b < 0) ? -mag : mag;
         end
         default: r.value = int_power(a, b);
      endcase
      return r;
   endfunction

   initial begin
      req_bus.valid = 1'b0;
      req_bus.a_value = '0;
      req_bus.b_value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.operation = OP_ADD;
   end

   // Sends one operand beat, with a random idle gap in front of it. Valid is
   // dropped only during an idle gap or before a register write, so it is
   // driven once per edge. The prediction is queued at the accepting edge, so
   // it uses the operation in force.
   task automatic send_operands(logic signed [31:0] a, logic signed [31:0] b);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.a_value <= a;
      req_bus.b_value <= b;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(alu_predict(a, b));
      ops_seen[active_op] = 1'b1;
      beats_sent++;
   endtask

   // Waits for the pipeline to drain, then writes the operation register.
   task automatic set_operation(logic [2:0] op);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.operation <= op;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      active_op = op;
   endtask

   // Receiver: random stall, and a long hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result checker: every accepted beat is compared with the oldest prediction.
   always @(posedge clock) begin
      alu_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result beat: result_value %0d", rsp_bus.result_value);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            beats_checked++;
            if (rsp_bus.result_value !== want.value) begin
               $error("result_value: expected %0d, got %0d", $signed(want.value),
                      rsp_bus.result_value);
               error_count++;
            end
            if (rsp_bus.divide_by_zero !== want.dz) begin
               $error("divide_by_zero: expected %0b, got %0b", want.dz,
                      rsp_bus.divide_by_zero);
               error_count++;
            end
         end
      end
   end

   // Random 32-bit operand, weighted toward edge values and small magnitudes.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(4)) - 2);
         3, 4: return 32'(int'($urandom_range(64)) - 32);
         default: return $urandom;
      endcase
   endfunction

   // Directed edge cases: each operation against the extremes and a shared list of corners.
   task automatic test_directed();
      logic [31:0] corners[6];
      corners = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int op = 0; op < 8; op++) begin
         set_operation(3'(op));
         send_operands(corners[0], corners[1]);
         send_operands(corners[1], corners[0]);
         send_operands(corners[0], corners[4]);
         send_operands(corners[2], corners[2]);
         send_operands(-32'sd7, 32'sd2);
         send_operands(32'sd7, -32'sd2);
         send_operands(-32'sd7, -32'sd2);
         send_operands(32'sd5, 32'sd0);
         send_operands(32'sd0, -32'sd3);
         send_operands(32'sd1, -32'sd5);
         send_operands(-32'sd1, -32'sd5);
         send_operands(-32'sd1, -32'sd4);
         send_operands(32'sd3, 32'sd40);
         send_operands(32'sd0, 32'sd0);
      end
   endtask

   // Random operands under randomly chosen operations, with the given idle and stall percentages.
   task automatic test_random(int beats, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < beats; i++) begin
         if (i % 35 == 0) set_operation(3'($urandom_range(7)));
         send_operands(pick_operand(), pick_operand());
      end
   endtask

   // Long receiver hold-off while the sender keeps offering beats, so the
   // pipeline fills and back-pressures the operand channel.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_operation(OP_DIV);
      hold_off_cycles = 200;
      for (int i = 0; i < 100; i++) send_operands($urandom, pick_operand());
   endtask

   initial begin
      hold_off_cycles = 0;
      error_count = 0;
      beats_sent = 0;
      beats_checked = 0;
      ops_seen = '0;
      active_op = OP_ADD;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250, 0, 0);
      test_random(250, 60, 0);
      test_random(250, 0, 60);
      test_random(250, 30, 30);
      test_backpressure();
      set_operation(OP_ADD);
      $display("Covered %0d operand beats, %0d results checked, operations seen mask %b.",
               beats_sent, beats_checked, ops_seen);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule
